// ----- rtl/fsba_pkg.sv -----
// fsba_pkg: shared types, constants and state codes for the fit-strategy allocator.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps
package fsba_pkg;

  localparam int POOL_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_SEGMENTS_DEF = 256;

  localparam int AW = 21;
  localparam int CW = 9;

  localparam logic [1:0] FUNC_ALLOC    = 2'd0;
  localparam logic [1:0] FUNC_FREE     = 2'd1;
  localparam logic [1:0] FUNC_FREE_ALL = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REG_FIT_STRATEGY = 1'b0;

  typedef struct packed {
    logic [1:0]    func;
    logic [AW-1:0] request_size;
    logic [AW-1:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [AW-1:0] payload_address;
    logic [CW-1:0] segment_count;
    logic [AW-1:0] bytes_in_use;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_EVAL,
    S_SLOT,
    S_SPLIT,
    S_MRD,
    S_MWAIT,
    S_MEVAL,
    S_DONE
  } fsm_state_t;

  // segment record: slot link is CW bits so the end marker fits
  typedef struct packed {
    logic [AW-1:0] offset;
    logic [AW:0]   size;
    logic          free;
    logic [CW-1:0] link;
  } seg_t;

endpackage

// ----- rtl/fsba_seg_mem.sv -----
// fsba_seg_mem: segment table memory, one write port and one registered read port.
// Depends on fsba_pkg.
`timescale 1ns / 1ps
module fsba_seg_mem #(
  parameter int MAX_SEGMENTS = fsba_pkg::MAX_SEGMENTS_DEF,
  parameter int IW = $clog2(MAX_SEGMENTS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IW-1:0]   waddr,
  input  fsba_pkg::seg_t  wdata,
  input  logic [IW-1:0]   raddr,
  output fsba_pkg::seg_t  rdata
);
  import fsba_pkg::*;

  seg_t mem [MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fsba_slot_alloc.sv -----
// fsba_slot_alloc: slot-in-use bits and a lowest-free-slot search.
// Depends on fsba_pkg.
`timescale 1ns / 1ps
module fsba_slot_alloc #(
  parameter int MAX_SEGMENTS = fsba_pkg::MAX_SEGMENTS_DEF,
  parameter int IW = $clog2(MAX_SEGMENTS)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          set_en,
  input  logic [IW-1:0] set_idx,
  input  logic          clr_en,
  input  logic [IW-1:0] clr_idx,
  output logic          found,
  output logic [IW-1:0] free_idx
);
  import fsba_pkg::*;

  logic [MAX_SEGMENTS-1:0] used_r;
  logic [MAX_SEGMENTS-1:0] used_nxt;

  always_comb begin
    used_nxt = used_r;
    if (clr_en) used_nxt[clr_idx] = 1'b0;
    if (set_en) used_nxt[set_idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      used_r[0] <= 1'b1;
    end else begin
      used_r <= used_nxt;
    end
  end

  // priority encoder for the lowest clear bit
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int s = MAX_SEGMENTS - 1; s >= 0; s--) begin
      if (!used_r[s]) begin
        found    = 1'b1;
        free_idx = IW'(s);
      end
    end
  end

endmodule

// ----- rtl/fit_strategy_block_allocator_unit.sv -----
// fit_strategy_block_allocator_unit: top level of the fit-strategy segment allocator.
// Depends on fsba_pkg, fsba_seg_mem and fsba_slot_alloc.
`timescale 1ns / 1ps
//
// Usage
//   Input channel: drive in_item and raise start while busy is low; that edge
//   is the transfer. busy falls in the cycle that shows the result, so the
//   next transfer can land at the edge that takes the result.
//   Result channel: out_valid is high for exactly one cycle with out_item;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: APB write of register 0 (fit_strategy) at byte address 0,
//   pready tied high, prdata returns the register. Write only while idle.
// Request processing
//   Every valid request walks the address-ordered segment chain segment by
//   segment (read, memory latency, evaluate) through the segment memory's one
//   read port. An allocate that finds space then passes the slot and split
//   steps before its result; a free takes the lookup walk plus, when the
//   address is found, one merge walk from the chain head; a free-all walks
//   the chain once. A request with an unknown func code does not walk.
//   One request is in flight at a time.
// Reset
//   rst_n low (synchronous) empties the pool to one free segment at slot 0.
//   Slot 0 is written during the first cycle after reset releases, so busy
//   is high for that one cycle; other slots are undefined until written.
module fit_strategy_block_allocator_unit #(
  parameter int POOL_BYTES   = fsba_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = fsba_pkg::HEADER_BYTES_DEF,
  parameter int MAX_SEGMENTS = fsba_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fsba_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fsba_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [0:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import fsba_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam logic [CW-1:0] END_MARK = CW'(MAX_SEGMENTS);
  localparam logic [AW:0]   HDR = (AW+1)'(HEADER_BYTES);
  localparam logic [AW:0]   INIT_SIZE = (AW+1)'(POOL_BYTES + HEADER_BYTES);

  // configuration register
  logic [1:0] fit_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, fit_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[0] == REG_FIT_STRATEGY) begin
      fit_r <= cfg_pwdata[1:0];
    end
  end

  fsm_state_t state_r, state_nxt;
  logic          init_r, init_nxt;
  in_item_t      req_r, req_nxt;
  logic [AW:0]   sz_r, sz_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;         // walk step counter
  logic [CW-1:0] pick_r, pick_nxt;
  logic [AW:0]   best_r, best_nxt;
  seg_t          pseg_r, pseg_nxt;        // chosen / merge-left segment
  logic [CW-1:0] chain_r, chain_nxt;
  logic [AW-1:0] used_r, used_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [AW-1:0] pay_r, pay_nxt;
  logic          vld_r, vld_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  seg_t          wdata, rdata;
  logic          s_set, s_clr, s_found;
  logic [IW-1:0] s_set_idx, s_clr_idx, s_free;

  fsba_seg_mem #(.MAX_SEGMENTS(MAX_SEGMENTS), .IW(IW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  fsba_slot_alloc #(.MAX_SEGMENTS(MAX_SEGMENTS), .IW(IW)) u_slot (
    .clk(clk), .rst_n(rst_n), .set_en(s_set), .set_idx(s_set_idx),
    .clr_en(s_clr), .clr_idx(s_clr_idx), .found(s_found), .free_idx(s_free)
  );

  assign busy      = (state_r != S_IDLE) || init_r;
  assign out_valid = vld_r;
  assign out_item  = '{status: stat_r, payload_address: pay_r,
                       segment_count: chain_r, bytes_in_use: used_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      init_r  <= 1'b1;
      chain_r <= CW'(1);
      used_r  <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      chain_r <= chain_nxt;
      used_r  <= used_nxt;
      vld_r   <= vld_nxt;
    end
    req_r  <= req_nxt;
    sz_r   <= sz_nxt;
    cur_r  <= cur_nxt;
    cnt_r  <= cnt_nxt;
    pick_r <= pick_nxt;
    best_r <= best_nxt;
    pseg_r <= pseg_nxt;
    stat_r <= stat_nxt;
    pay_r  <= pay_nxt;
  end

  logic [AW:0] usable, diff, psz_usable;
  logic        fits, last;
  logic [CW-1:0] nxt_link;

  always_comb begin
    usable     = rdata.size - HDR;
    diff       = usable - sz_r;
    fits       = rdata.free && (usable >= sz_r);
    nxt_link   = (rdata.link < END_MARK) ? rdata.link : END_MARK;
    last       = (nxt_link == END_MARK) || (cnt_r == END_MARK - CW'(1));
    psz_usable = pseg_r.size - HDR;
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = 1'b0;
    req_nxt   = req_r;
    sz_nxt    = sz_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    pick_nxt  = pick_r;
    best_nxt  = best_r;
    pseg_nxt  = pseg_r;
    chain_nxt = chain_r;
    used_nxt  = used_r;
    stat_nxt  = stat_r;
    pay_nxt   = pay_r;
    vld_nxt   = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = rdata;
    raddr     = cur_r[IW-1:0];
    s_set     = 1'b0;
    s_set_idx = s_free;
    s_clr     = 1'b0;
    s_clr_idx = '0;

    if (init_r) begin
      // seed slot 0 with the whole pool
      we    = 1'b1;
      waddr = '0;
      wdata = '{offset: '0, size: INIT_SIZE, free: 1'b1, link: END_MARK};
    end

    unique case (state_r)
      S_IDLE: begin
        if (start && !init_r) begin
          req_nxt  = in_item;
          sz_nxt   = ({1'b0, in_item.request_size} + (AW+1)'(3)) & ~((AW+1)'(3));
          cur_nxt  = '0;
          cnt_nxt  = '0;
          pick_nxt = END_MARK;
          best_nxt = '0;
          stat_nxt = ST_OK;
          pay_nxt  = '0;
          if (in_item.func == FUNC_ALLOC || in_item.func == FUNC_FREE ||
              in_item.func == FUNC_FREE_ALL) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        raddr     = cur_r[IW-1:0];
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_RD;
        cur_nxt   = nxt_link;
        cnt_nxt   = cnt_r + CW'(1);
        priority case (req_r.func)
          FUNC_ALLOC: begin
            if (fits) begin
              if (fit_r == FIT_BEST) begin
                if (pick_r == END_MARK || diff < best_r) begin
                  pick_nxt = cur_r; best_nxt = diff; pseg_nxt = rdata;
                end
              end else if (fit_r == FIT_WORST) begin
                if (pick_r == END_MARK || diff > best_r) begin
                  pick_nxt = cur_r; best_nxt = diff; pseg_nxt = rdata;
                end
              end else begin
                pick_nxt = cur_r; pseg_nxt = rdata;
                state_nxt = S_SLOT;
              end
            end
            if (last && state_nxt != S_SLOT) begin
              state_nxt = S_SLOT;
              if (!(fits && (fit_r == FIT_BEST || fit_r == FIT_WORST)) &&
                  pick_r == END_MARK) begin
                stat_nxt  = ST_NOSPACE;
                state_nxt = S_DONE;
              end
            end
          end
          FUNC_FREE: begin
            if ({1'b0, rdata.offset} + HDR == {1'b0, req_r.release_address}) begin
              if (!rdata.free) begin
                used_nxt = (used_r >= usable[AW-1:0]) ? used_r - usable[AW-1:0] : '0;
                we    = 1'b1;
                waddr = cur_r[IW-1:0];
                wdata = rdata;
                wdata.free = 1'b1;
              end
              cur_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_MRD;
            end else if (last) begin
              stat_nxt  = ST_UNKNOWN;
              state_nxt = S_DONE;
            end
          end
          default: begin
            we    = 1'b1;
            waddr = cur_r[IW-1:0];
            wdata = rdata;
            wdata.free = 1'b1;
            used_nxt = '0;
            if (last) state_nxt = S_DONE;
          end
        endcase
      end
      S_SLOT: begin
        // chosen segment is in pseg_r; split when leftover exceeds one header and a slot is free
        pay_nxt = pseg_r.offset + HDR[AW-1:0];
        if ((psz_usable - sz_r > HDR) && s_found) begin
          we    = 1'b1;
          waddr = s_free;
          wdata = '{offset: pseg_r.offset + HDR[AW-1:0] + sz_r[AW-1:0],
                    size: pseg_r.size - sz_r - HDR, free: 1'b1, link: pseg_r.link};
          s_set     = 1'b1;
          s_set_idx = s_free;
          chain_nxt = chain_r + CW'(1);
          used_nxt  = used_r + sz_r[AW-1:0];
          pseg_nxt.link = {{(CW-IW){1'b0}}, s_free};
          pseg_nxt.size = sz_r + HDR;
        end else begin
          used_nxt = used_r + psz_usable[AW-1:0];
        end
        pseg_nxt.free = 1'b0;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        we        = 1'b1;
        waddr     = pick_r[IW-1:0];
        wdata     = pseg_r;
        state_nxt = S_DONE;
      end
      // merge walk: cur is the segment being read, pick and pseg hold the left segment
      S_MRD: begin
        raddr     = cur_r[IW-1:0];
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        state_nxt = S_MEVAL;
      end
      S_MEVAL: begin
        // first visit loads the left segment; later visits read the right one
        if (cnt_r == '0) begin
          pseg_nxt = rdata;
          if (nxt_link == END_MARK) begin
            state_nxt = S_DONE;
          end else begin
            pick_nxt  = cur_r;
            cur_nxt   = nxt_link;
            cnt_nxt   = CW'(1);
            state_nxt = S_MRD;
          end
        end else if (pseg_r.free && rdata.free &&
                     {1'b0, pseg_r.offset} + pseg_r.size == {1'b0, rdata.offset}) begin
          pseg_nxt.size = pseg_r.size + rdata.size;
          pseg_nxt.link = rdata.link;
          we    = 1'b1;
          waddr = pick_r[IW-1:0];
          wdata = pseg_nxt;
          s_clr     = 1'b1;
          s_clr_idx = cur_r[IW-1:0];
          if (chain_r > CW'(1)) chain_nxt = chain_r - CW'(1);
          if (nxt_link == END_MARK) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = nxt_link;
            state_nxt = S_MRD;
          end
        end else begin
          pseg_nxt = rdata;
          pick_nxt = cur_r;
          if (nxt_link == END_MARK) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = nxt_link;
            state_nxt = S_MRD;
          end
        end
      end
      S_DONE: begin
        vld_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- verif/tb.sv -----
// tb: self-checking bench for fit_strategy_block_allocator_unit.
// Depends on fsba_pkg and the allocator RTL; keeps its own segment-chain predictor.
`timescale 1ns / 1ps
module tb;
  import fsba_pkg::*;

  localparam int unsigned POOL   = 1048576;
  localparam int unsigned HDR    = 32;
  localparam int unsigned NSEG   = 256;
  localparam int unsigned ENDM   = NSEG;
  localparam longint      LIMIT  = 64'd40000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fit_strategy_block_allocator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the allocator: segment tables, chain head is always slot 0.
  int unsigned seg_off  [NSEG];
  int unsigned seg_size [NSEG];
  bit          seg_free [NSEG];
  int unsigned seg_next [NSEG];
  bit          slot_busy[NSEG];
  int unsigned chain_len;
  int unsigned bytes_held;
  logic [1:0]  placement;

  out_item_t   result_fifo[$];
  in_item_t    req_fifo[$];
  int unsigned live_payloads[$];

  int  errors = 0;
  int  n_sent = 0, n_checked = 0, n_nospace = 0, n_unknown = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;

  function automatic void shadow_reset();
    for (int s = 0; s < NSEG; s++) begin
      seg_off[s] = 0; seg_size[s] = 0; seg_free[s] = 0;
      seg_next[s] = 0; slot_busy[s] = 0;
    end
    seg_size[0] = POOL + HDR;
    seg_free[0] = 1;
    seg_next[0] = ENDM;
    slot_busy[0] = 1;
    chain_len = 1;
    bytes_held = 0;
    placement = '0;
    live_payloads.delete();
  endfunction

  function automatic void coalesce_chain();
    int unsigned i, j, guard;
    i = 0;
    guard = 0;
    while (i < NSEG && guard < 2 * NSEG) begin
      j = seg_next[i];
      guard++;
      if (j >= NSEG) break;
      if (seg_free[i] && seg_free[j] && seg_off[i] + seg_size[i] == seg_off[j]) begin
        seg_size[i] += seg_size[j];
        seg_next[i] = seg_next[j];
        slot_busy[j] = 0;
        if (chain_len > 1) chain_len--;
        continue;
      end
      i = j;
    end
  endfunction

  // Apply one request to the shadow and return what the block must report.
  function automatic out_item_t allocator_predict(in_item_t it);
    out_item_t   r;
    int unsigned sz, pick, gap, best, usable, i, n, s, hit;
    r = '0;
    case (it.func)
      FUNC_ALLOC: begin
        sz = (int'(it.request_size) + 3) & ~32'd3;
        pick = ENDM;
        best = 0;
        i = 0;
        for (n = 0; i != ENDM && n < NSEG; n++) begin
          usable = seg_size[i] - HDR;
          if (seg_free[i] && usable >= sz) begin
            gap = usable - sz;
            if (placement == FIT_BEST) begin
              if (pick == ENDM || gap < best) begin pick = i; best = gap; end
            end else if (placement == FIT_WORST) begin
              if (pick == ENDM || gap > best) begin pick = i; best = gap; end
            end else begin
              pick = i;
              break;
            end
          end
          i = seg_next[i];
        end
        if (pick == ENDM) begin
          r.status = ST_NOSPACE;
        end else begin
          usable = seg_size[pick] - HDR;
          s = ENDM;
          if (usable - sz > HDR)
            for (int k = 0; k < NSEG; k++)
              if (!slot_busy[k]) begin s = k; break; end
          if (s != ENDM) begin
            seg_off[s] = seg_off[pick] + HDR + sz;
            seg_size[s] = seg_size[pick] - sz - HDR;
            seg_free[s] = 1;
            seg_next[s] = seg_next[pick];
            slot_busy[s] = 1;
            seg_next[pick] = s;
            seg_size[pick] = sz + HDR;
            chain_len++;
            bytes_held += sz;
          end else begin
            // no split: charge the whole payload
            bytes_held += usable;
          end
          seg_free[pick] = 0;
          r.payload_address = AW'(seg_off[pick] + HDR);
          live_payloads.push_back(seg_off[pick] + HDR);
        end
      end
      FUNC_FREE: begin
        hit = ENDM;
        i = 0;
        for (n = 0; i != ENDM && n < NSEG; n++) begin
          if (seg_off[i] + HDR == it.release_address) begin hit = i; break; end
          i = seg_next[i];
        end
        if (hit == ENDM) begin
          r.status = ST_UNKNOWN;
        end else begin
          if (!seg_free[hit]) begin
            usable = seg_size[hit] - HDR;
            bytes_held = bytes_held >= usable ? bytes_held - usable : 0;
            seg_free[hit] = 1;
          end
          foreach (live_payloads[k])
            if (live_payloads[k] == it.release_address) begin
              live_payloads.delete(k);
              break;
            end
          coalesce_chain();
        end
      end
      FUNC_FREE_ALL: begin
        i = 0;
        for (n = 0; i != ENDM && n < NSEG; n++) begin
          seg_free[i] = 1;
          i = seg_next[i];
        end
        bytes_held = 0;
        live_payloads.delete();
      end
      default: ;
    endcase
    r.segment_count = CW'(chain_len);
    r.bytes_in_use = AW'(bytes_held);
    return r;
  endfunction

  // Driver: one transfer per start && !busy edge, random idle bursts between.
  int unsigned idle_left = 0;
  always @(posedge clk) begin
    logic next_start;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        // transfer happened at this edge: predict now, then advance
        result_fifo.push_back(allocator_predict(in_item));
        n_sent++;
        next_start = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0)
          idle_left = $urandom_range(1, 14);
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (req_fifo.size() > 0) begin
          in_item <= req_fifo.pop_front();
          next_start = 1'b1;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: results cannot be held off, so check them on the strobe.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (result_fifo.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        errors++;
      end else begin
        exp_r = result_fifo.pop_front();
        n_checked++;
        if (out_item.status != exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_item.status); errors++;
        end
        if (out_item.payload_address != exp_r.payload_address) begin
          $error("payload_address exp %0d got %0d", exp_r.payload_address,
                 out_item.payload_address); errors++;
        end
        if (out_item.segment_count != exp_r.segment_count) begin
          $error("segment_count exp %0d got %0d", exp_r.segment_count,
                 out_item.segment_count); errors++;
        end
        if (out_item.bytes_in_use != exp_r.bytes_in_use) begin
          $error("bytes_in_use exp %0d got %0d", exp_r.bytes_in_use,
                 out_item.bytes_in_use); errors++;
        end
        if (exp_r.status == ST_NOSPACE) n_nospace++;
        if (exp_r.status == ST_UNKNOWN) n_unknown++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_FIT_STRATEGY; cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    placement = value;
    // read back in one setup/access pair
    @(posedge clk);
    cfg_psel <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[1:0] != value) begin
      $error("fit_strategy exp %0d got %0d", value, cfg_prdata[1:0]); errors++;
    end
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
  endtask

  // Hold until every queued request has gone and every result has come back.
  task automatic drain();
    @(posedge clk);
    while (req_fifo.size() > 0 || start || result_fifo.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push_req(logic [1:0] f, int unsigned sz, int unsigned addr);
    in_item_t it;
    it.func = f;
    it.request_size = sz[20:0];
    it.release_address = addr[20:0];
    @(posedge clk);
    while (req_fifo.size() > 0) @(posedge clk);
    req_fifo.push_back(it);
  endtask

  function automatic int unsigned pick_size();
    int unsigned b;
    b = $urandom_range(0, 99);
    if (b < 60) return $urandom_range(0, 256);
    if (b < 85) return $urandom_range(0, 8192);
    if (b < 93) return $urandom_range(0, 131072);
    if (b < 98) return $urandom_range(0, POOL);
    return $urandom_range(0, 1) ? 21'h0FFFFF : POOL;
  endfunction

  function automatic int unsigned pick_addr();
    if (live_payloads.size() > 0 && $urandom_range(0, 9) < 8)
      return live_payloads[$urandom_range(0, live_payloads.size() - 1)];
    return $urandom_range(0, 1) ? $urandom_range(0, POOL + HDR)
                                : ($urandom_range(0, 4096) * 4 + HDR);
  endfunction

  // One random stretch: mostly alloc/free pairs, rare free-all and func 3.
  task automatic random_run(int count, int fill_bias);
    int unsigned b;
    for (int k = 0; k < count; k++) begin
      b = $urandom_range(0, 99);
      if (b < fill_bias)       push_req(FUNC_ALLOC, $urandom_range(0, 64), $urandom);
      else if (b < 52)         push_req(FUNC_ALLOC, pick_size(), $urandom);
      else if (b < 96)         push_req(FUNC_FREE, $urandom, pick_addr());
      else if (b < 98)         push_req(FUNC_FREE_ALL, $urandom, $urandom);
      else                     push_req(2'd3, $urandom, $urandom);
    end
  endtask

  initial begin
    shadow_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every func, unknown address, double free.
    push_req(FUNC_ALLOC, 0, 0);
    push_req(FUNC_ALLOC, 1, 0);
    push_req(FUNC_ALLOC, POOL, 0);          // does not fit any more
    push_req(FUNC_FREE, 0, POOL + HDR);      // unknown address
    push_req(FUNC_FREE, 0, 0);
    push_req(FUNC_FREE, 0, HDR);
    push_req(FUNC_FREE, 0, HDR);             // free of a free segment
    push_req(FUNC_FREE, 0, HDR + 36);
    push_req(2'd3, 21'h1FFFFF, 21'h1FFFFF);
    push_req(FUNC_ALLOC, POOL, 0);           // does not fit either: the second allocation is still held
    push_req(FUNC_ALLOC, 4, 0);
    push_req(FUNC_FREE_ALL, 0, 0);
    push_req(FUNC_FREE, 0, HDR);
    push_req(FUNC_ALLOC, 21'h1FFFFF, 21'h1FFFFF);
    push_req(FUNC_ALLOC, 100, 0);
    push_req(FUNC_ALLOC, 200, 0);
    push_req(FUNC_FREE, 0, HDR);
    drain();

    // best fit and worst fit on holes of different size
    for (int st = 1; st <= 2; st++) begin
      reg_write(st[1:0]);
      push_req(FUNC_ALLOC, 40, 0);
      push_req(FUNC_FREE, 0, live_payloads.size() ? live_payloads[0] : HDR);
      push_req(FUNC_ALLOC, 8, 0);
      drain();
    end

    // Random phases across strategies; one phase fills the slot table.
    reg_write(FIT_BEST);     random_run(350, 0);   drain();
    reg_write(2'd3);         random_run(200, 0);   drain();
    reg_write(2'd0);         random_run(400, 45);  drain();
    reg_write(FIT_WORST);    random_run(350, 10);  drain();
    reg_write(2'd0);         random_run(200, 0);   drain();
    quiet = 1'b1;
    reg_write(FIT_BEST);     random_run(200, 20);
    drain();
    repeat (100) @(posedge clk);

    $display("items %0d, results checked %0d (no-space %0d, unknown address %0d)",
             n_sent, n_checked, n_nospace, n_unknown);
    $display("all four placement settings, table-full and whole-pool cases visited");
    if (errors == 0 && result_fifo.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
